FILE: rtl/wqc_pkg.sv
// Shared types, codes and sizes of the waiting queue with cancel.
package wqc_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ID_BITS     = 16;

  localparam int unsigned PORT_ID_W  = 16;
  localparam int unsigned ID_W       = (ID_BITS < PORT_ID_W) ? ID_BITS : PORT_ID_W;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned AW         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW         = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CMD_W      = 3;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned OUT_DATA_W = 56;

  typedef enum logic [CMD_W-1:0] {
    CMD_ARRIVE = 3'd0,
    CMD_SERVE  = 3'd1,
    CMD_CANCEL = 3'd2,
    CMD_LIST   = 3'd3,
    CMD_TICK   = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SERVE,
    ST_CANCEL,
    ST_LIST,
    ST_DROP
  } state_e;

  typedef struct packed {
    logic [TICK_W-1:0] stamp;
    logic [ID_W-1:0]   id;
  } entry_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] addr;
    entry_t        data;
  } mem_wr_t;

endpackage

FILE: rtl/wqc_mem.sv
// Entry store of the waiting queue: one write port and one registered read port.
module wqc_mem
  import wqc_pkg::*;
(
  input  logic          clk_i,
  input  mem_wr_t       wr_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/wqc_alu.sv
// Shared compare and subtract unit: id match and waiting time of one entry.
module wqc_alu
  import wqc_pkg::*;
(
  input  logic [TICK_W-1:0] now_i,
  input  entry_t            entry_i,
  input  logic [ID_W-1:0]   key_i,
  output logic [TICK_W-1:0] wait_o,
  output logic              match_o
);

  assign wait_o  = now_i - entry_i.stamp;
  assign match_o = (entry_i.id == key_i);

endmodule

FILE: rtl/waiting_queue_with_cancel_top.sv
// Top level of the waiting queue with cancel: command sequencer and result register.
//
//   Channel   Direction  Contents
//   s_axis    in         tuser cmd, tdata user_id
//   m_axis    out        tdata status, out_id, wait_ticks; tlast last
//
// Arrive, tick, an unused code and any command on an empty queue finish in the execute state.
// Serve, cancel and list then walk the entries held one at a time.
// Cancel scans up to the match, then moves the entries behind it up by one place.
// The shared unit and the single memory port make these walks serial.
// Reset clears the state, pointer, count, tick counter and output valid; there is no clearing pass.
// A stalled result holds the sequencer at its next result; a new command waits for idle.
module waiting_queue_with_cancel_top
  import wqc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [PORT_ID_W-1:0]  s_axis_tdata,  // [15:0] user_id
  input  logic [CMD_W-1:0]      s_axis_tuser,  // [2:0] cmd
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [1:0] status, [17:2] out_id,
                                               // [49:18] wait_ticks, [55:50] zero
  output logic                  m_axis_tlast
);

  state_e            state_q, state_d;
  logic [CMD_W-1:0]  cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [CW-1:0]     ptr_q, ptr_d;
  logic [CW-1:0]     occ_q, occ_d;
  logic [TICK_W-1:0] now_q, now_d;
  logic              out_valid_q, out_valid_d;
  logic [OUT_DATA_W-1:0] out_data_q;
  logic              out_last_q;

  logic              s_fire;
  logic              out_free;
  logic              full;
  logic              ptr_last;
  logic [CW-1:0]     ptr_inc;
  logic [CW-1:0]     ptr_prev;

  mem_wr_t           wr;
  entry_t            rd;
  logic [TICK_W-1:0] alu_wait;
  logic              alu_match;

  logic              emit;
  status_e           res_status;
  logic [ID_W-1:0]   res_id;
  logic [TICK_W-1:0] res_wait;
  logic              res_last;
  logic              drop_start;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign full          = (occ_q == CW'(QUEUE_DEPTH));
  assign ptr_inc       = ptr_q + CW'(1);
  assign ptr_prev      = ptr_q - CW'(1);
  assign ptr_last      = (ptr_inc == occ_q);

  wqc_mem u_mem (
    .clk_i   (clk_i),
    .wr_i    (wr),
    .raddr_i (ptr_d[AW-1:0]),
    .rdata_o (rd)
  );

  wqc_alu u_alu (
    .now_i   (now_q),
    .entry_i (rd),
    .key_i   (id_q),
    .wait_o  (alu_wait),
    .match_o (alu_match)
  );

  always_comb begin
    emit       = 1'b0;
    res_status = STAT_OK;
    res_id     = '0;
    res_wait   = '0;
    res_last   = 1'b1;
    drop_start = 1'b0;
    wr         = '0;
    case (state_q)
      ST_EXEC: begin
        case (cmd_q)
          CMD_ARRIVE: begin
            if (out_free) begin
              emit   = 1'b1;
              res_id = id_q;
              if (full) begin
                res_status = STAT_FULL;
              end else begin
                wr.we         = 1'b1;
                wr.addr       = occ_q[AW-1:0];
                wr.data.stamp = now_q;
                wr.data.id    = id_q;
              end
            end
          end
          CMD_SERVE, CMD_LIST: begin
            if (occ_q == '0 && out_free) begin
              emit       = 1'b1;
              res_status = STAT_EMPTY;
            end
          end
          CMD_CANCEL: begin
            if (occ_q == '0 && out_free) begin
              emit       = 1'b1;
              res_status = STAT_NOT_FOUND;
              res_id     = id_q;
            end
          end
          default: ;
        endcase
      end
      ST_SERVE: begin
        if (out_free) begin
          emit       = 1'b1;
          res_id     = rd.id;
          res_wait   = alu_wait;
          drop_start = 1'b1;
        end
      end
      ST_CANCEL: begin
        if (alu_match) begin
          if (out_free) begin
            emit       = 1'b1;
            res_id     = id_q;
            drop_start = 1'b1;
          end
        end else if (ptr_last && out_free) begin
          emit       = 1'b1;
          res_status = STAT_NOT_FOUND;
          res_id     = id_q;
        end
      end
      ST_LIST: begin
        if (out_free) begin
          emit     = 1'b1;
          res_id   = rd.id;
          res_wait = alu_wait;
          res_last = ptr_last;
        end
      end
      ST_DROP: begin
        wr.we   = 1'b1;
        wr.addr = ptr_prev[AW-1:0];
        wr.data = rd;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    occ_d   = occ_q;
    now_d   = now_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ptr_d = '0;
        case (cmd_q)
          CMD_ARRIVE: begin
            if (emit) begin
              state_d = ST_IDLE;
              if (!full) begin
                occ_d = occ_q + CW'(1);
              end
            end
          end
          CMD_SERVE: begin
            if (occ_q != '0) begin
              state_d = ST_SERVE;
            end else if (emit) begin
              state_d = ST_IDLE;
            end
          end
          CMD_CANCEL: begin
            if (occ_q != '0) begin
              state_d = ST_CANCEL;
            end else if (emit) begin
              state_d = ST_IDLE;
            end
          end
          CMD_LIST: begin
            if (occ_q != '0) begin
              state_d = ST_LIST;
            end else if (emit) begin
              state_d = ST_IDLE;
            end
          end
          CMD_TICK: begin
            now_d   = now_q + TICK_W'(1);
            state_d = ST_IDLE;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_SERVE, ST_CANCEL: begin
        if (drop_start) begin
          if (ptr_last) begin
            occ_d   = occ_q - CW'(1);
            state_d = ST_IDLE;
          end else begin
            ptr_d   = ptr_inc;
            state_d = ST_DROP;
          end
        end else if (state_q == ST_CANCEL && !alu_match) begin
          if (ptr_last) begin
            if (emit) begin
              state_d = ST_IDLE;
            end
          end else begin
            ptr_d = ptr_inc;
          end
        end
      end
      ST_LIST: begin
        if (emit) begin
          if (ptr_last) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d = ptr_inc;
          end
        end
      end
      ST_DROP: begin
        if (ptr_last) begin
          occ_d   = occ_q - CW'(1);
          state_d = ST_IDLE;
        end else begin
          ptr_d = ptr_inc;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      occ_q       <= '0;
      now_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      occ_q       <= occ_d;
      now_q       <= now_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      cmd_q <= s_axis_tuser;
      id_q  <= s_axis_tdata[ID_W-1:0];
    end
    if (emit) begin
      out_data_q <= {6'd0, res_wait, PORT_ID_W'(res_id), res_status};
      out_last_q <= res_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

FILE: sim/tb_waiting_queue_with_cancel_top.sv
// Self-checking testbench of the waiting queue with cancel, with its own model of the queue.
module tb_waiting_queue_with_cancel_top
  import wqc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = CMD_W'(CMD_TICK) + 3'd1;
  localparam int               HOLD_CYCLES     = 300;
  localparam int               RANDOM_ITEMS    = 400;

  typedef struct {
    status_e            status;
    logic [PORT_ID_W-1:0] out_id;
    logic [TICK_W-1:0]  wait_ticks;
    logic               last;
  } queue_result_t;

  class waiting_line_tracker;
    logic [PORT_ID_W-1:0] line_ids[$];
    logic [TICK_W-1:0]    line_stamps[$];
    logic [TICK_W-1:0]    tick_count;
    queue_result_t        owed_results[$];
    int unsigned          mismatches;

    function new();
      tick_count = '0;
      mismatches = 0;
    endfunction

    function void owe(status_e st, logic [PORT_ID_W-1:0] id, logic [TICK_W-1:0] waited,
                      logic lst);
      queue_result_t r;
      r.status     = st;
      r.out_id     = id;
      r.wait_ticks = waited;
      r.last       = lst;
      owed_results.push_back(r);
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [PORT_ID_W-1:0] raw_id);
      logic [PORT_ID_W-1:0] id;
      int                   hit;
      id  = PORT_ID_W'(raw_id[ID_W-1:0]);
      hit = -1;
      case (cmd)
        CMD_ARRIVE: begin
          if (line_ids.size() >= QUEUE_DEPTH) begin
            owe(STAT_FULL, id, '0, 1'b1);
          end else begin
            line_ids.push_back(id);
            line_stamps.push_back(tick_count);
            owe(STAT_OK, id, '0, 1'b1);
          end
        end
        CMD_SERVE: begin
          if (line_ids.size() == 0) begin
            owe(STAT_EMPTY, '0, '0, 1'b1);
          end else begin
            owe(STAT_OK, line_ids[0], tick_count - line_stamps[0], 1'b1);
            void'(line_ids.pop_front());
            void'(line_stamps.pop_front());
          end
        end
        CMD_CANCEL: begin
          for (int i = 0; i < line_ids.size() && hit < 0; i++) begin
            if (line_ids[i] == id) hit = i;
          end
          if (hit < 0) begin
            owe(STAT_NOT_FOUND, id, '0, 1'b1);
          end else begin
            line_ids.delete(hit);
            line_stamps.delete(hit);
            owe(STAT_OK, id, '0, 1'b1);
          end
        end
        CMD_LIST: begin
          if (line_ids.size() == 0) begin
            owe(STAT_EMPTY, '0, '0, 1'b1);
          end else begin
            foreach (line_ids[i]) begin
              owe(STAT_OK, line_ids[i], tick_count - line_stamps[i], i == line_ids.size() - 1);
            end
          end
        end
        CMD_TICK: tick_count = tick_count + 1'b1;
        default: ;
      endcase
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [PORT_ID_W-1:0] id,
                               logic [TICK_W-1:0] waited, logic lst);
      queue_result_t want;
      if (owed_results.size() == 0) begin
        $error("unexpected result: status %0d, out_id %0h", status, id);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        mismatches++;
      end
      if (id !== want.out_id) begin
        $error("out_id: expected %0h, actual %0h", want.out_id, id);
        mismatches++;
      end
      if (waited !== want.wait_ticks) begin
        $error("wait_ticks: expected %0d, actual %0d", want.wait_ticks, waited);
        mismatches++;
      end
      if (lst !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, lst);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [PORT_ID_W-1:0]  s_axis_tdata  = '0;
  logic [CMD_W-1:0]      s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  waiting_line_tracker tracker = new();

  bit steady        = 1'b0;
  int hold_requests = 0;
  int holds_done    = 0;
  int hold_left     = 0;

  waiting_queue_with_cancel_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3_000_000;
    $display("[waiting_queue_with_cancel_top] ERROR");
    $finish;
  end

  // A requested hold keeps the result side stalled while the command side keeps offering.
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= steady || ($urandom_range(99) >= 9);
    end
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      tracker.check_result(m_axis_tdata[STATUS_W-1:0],
                           m_axis_tdata[STATUS_W +: PORT_ID_W],
                           m_axis_tdata[STATUS_W + PORT_ID_W +: TICK_W],
                           m_axis_tlast);
    end
  end

  // Called just after a falling edge; returns just after the falling edge that follows the
  // transaction, with tvalid still set so that a following command can keep it high.
  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [PORT_ID_W-1:0] id);
    while (!steady && $urandom_range(99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= id;
    do @(posedge clk_i); while (!s_axis_tready);
    tracker.note_command(cmd, id);
    @(negedge clk_i);
  endtask

  initial begin
    logic [CMD_W-1:0]     opening_cmds[22];
    logic [PORT_ID_W-1:0] opening_ids[22];
    cmd_e                 cmd_order[5];
    int                   cuts[3][5];
    logic [CMD_W-1:0]     cmd;
    logic [PORT_ID_W-1:0] id;
    int                   sent;
    int                   mode;
    int                   pick;
    int                   k;
    bit                   paused;

    opening_cmds = '{CMD_LIST, CMD_SERVE, CMD_CANCEL, CMD_SPARE_FIRST,
                     CMD_SPARE_FIRST + 3'd1, CMD_SPARE_FIRST + 3'd2, CMD_ARRIVE, CMD_TICK,
                     CMD_ARRIVE, CMD_ARRIVE, CMD_TICK, CMD_TICK, CMD_ARRIVE, CMD_LIST,
                     CMD_CANCEL, CMD_CANCEL, CMD_LIST, CMD_SERVE, CMD_CANCEL, CMD_SERVE,
                     CMD_SERVE, CMD_LIST};
    opening_ids  = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000,
                     16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h5A5A, 16'h0000,
                     16'h0000, 16'h1234, 16'hFFFF, 16'h0000, 16'h5A5A, 16'hFFFF,
                     16'h0000, 16'hFFFF};
    cmd_order    = '{CMD_ARRIVE, CMD_SERVE, CMD_CANCEL, CMD_LIST, CMD_TICK};
    cuts         = '{'{55, 62, 72, 80, 97}, '{15, 45, 70, 80, 97}, '{30, 45, 62, 74, 97}};
    paused       = 1'b0;
    mode         = 2;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (opening_cmds[i]) send_command(opening_cmds[i], opening_ids[i]);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 40 == 0) mode = $urandom_range(2);
      if (sent == 120 && hold_requests == 0) begin
        mode = 0;
        hold_requests++;
      end
      if (sent == 260 && !paused) begin
        paused = 1'b1;
        s_axis_tvalid <= 1'b0;
        do @(negedge clk_i); while (tracker.owed_results.size() != 0);
      end
      steady = (sent >= 300 && sent < 360);

      pick = $urandom_range(99);
      k    = 0;
      while (k < 5 && pick >= cuts[mode][k]) k++;
      cmd = (k < 5) ? CMD_W'(cmd_order[k]) : CMD_SPARE_FIRST + CMD_W'($urandom_range(2));

      if (cmd == CMD_CANCEL && tracker.line_ids.size() != 0 && $urandom_range(99) < 70) begin
        id = tracker.line_ids[$urandom_range(tracker.line_ids.size() - 1)];
      end else if ($urandom_range(99) < 40) begin
        id = PORT_ID_W'($urandom_range(7));
      end else begin
        id = PORT_ID_W'($urandom);
      end

      send_command(cmd, id);
      if (cmd <= CMD_W'(CMD_TICK)) sent++;
    end

    s_axis_tvalid <= 1'b0;
    steady = 1'b0;
    do @(negedge clk_i); while (tracker.owed_results.size() != 0);
    repeat (40) @(negedge clk_i);

    if (tracker.mismatches == 0 && tracker.owed_results.size() == 0) begin
      $display("[waiting_queue_with_cancel_top] OK");
    end else begin
      $display("[waiting_queue_with_cancel_top] ERROR");
    end
    $finish;
  end

endmodule

FILE: waiting_queue_with_cancel_top.f
rtl/wqc_pkg.sv
rtl/wqc_mem.sv
rtl/wqc_alu.sv
rtl/waiting_queue_with_cancel_top.sv
sim/tb_waiting_queue_with_cancel_top.sv
